FILE: design/jsce_pkg.sv
// ----------------------------------------------------------------------------
// jsce_pkg
// Shared constants, opcodes and the job record passed from the front end to
// the byte sequencer of the JTAG shift command encoder.
// ----------------------------------------------------------------------------
package jsce_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int COUNT_BITS  = 20;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int BIR_W       = $clog2(BLOCK_BYTES);
    localparam int LEN_W       = 16;

    localparam int MAX_RES     = 7;
    localparam int RES_CNT_W   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // item modes
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // run kinds
    localparam logic [1:0] RUN_BLOCK = 2'd0;
    localparam logic [1:0] RUN_BYTES = 2'd1;
    localparam logic [1:0] RUN_FINAL = 2'd2;

    // serial engine opcodes
    localparam logic [7:0] OP_BYTES_RD = 8'h39;
    localparam logic [7:0] OP_BYTES_WR = 8'h19;
    localparam logic [7:0] OP_BITS_RD  = 8'h3b;
    localparam logic [7:0] OP_BITS_WR  = 8'h1b;
    localparam logic [7:0] OP_TMS_RD   = 8'h6b;
    localparam logic [7:0] OP_TMS_WR   = 8'h4b;
    localparam logic [7:0] CMD_FLUSH   = 8'h87;
    localparam logic [7:0] BYTE_MASK   = 8'hFF;
    localparam logic [7:0] NB_MASK     = 8'h0F;
    localparam logic [7:0] LASTBIT_FLG = 8'h80;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [RES_CNT_W-1:0]    count;
        logic                    err;
    } t_job;

endpackage

FILE: design/jsce_if.sv
// ----------------------------------------------------------------------------
// jsce_if
// Valid/ready channels carrying shift requests in and command bytes out.
// ----------------------------------------------------------------------------
interface jsce_in_if import jsce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COUNT_BITS-1:0] bit_count;
    logic                  read_en;
    logic                  end_tms;
    logic [7:0]            data_byte;

    modport source (output valid, mode, bit_count, read_en, end_tms, data_byte,
                    input ready);
    modport sink   (input valid, mode, bit_count, read_en, end_tms, data_byte,
                    output ready);
endinterface

interface jsce_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic       error;
    logic       last;

    modport source (output valid, cmd_byte, error, last, input ready);
    modport sink   (input valid, cmd_byte, error, last, output ready);
endinterface

FILE: design/jtag_shift_command_encoder.sv
// ----------------------------------------------------------------------------
// jtag_shift_command_encoder
// Encodes one JTAG data shift into serial-engine command bytes.
// ----------------------------------------------------------------------------
// A begin request opens a shift; each data request is then accepted and queued
// as a job of one to seven output bytes. While o_res.ready holds, the output
// emits one byte per cycle from a registered stage, so bursts of plain data
// bytes stream at one request per cycle, while requests that add a run header,
// a flush or the closing TMS command occupy the output for up to seven bytes;
// a four-entry job queue absorbs these and input stalls only once it fills.
// A request's job is written into the queue, then its first byte passes the
// registered output stage. Errors (data with no open shift, zero count, begin
// during a shift) produce a single byte of zero with error and last set.
// ----------------------------------------------------------------------------
module jtag_shift_command_encoder import jsce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsce_in_if.sink    i_cmd,
    jsce_out_if.source o_res
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_head;

    jsce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    jsce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (job_head)
    );

    jsce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (job_head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

FILE: design/jsce_front.sv
// ----------------------------------------------------------------------------
// jsce_front
// Accepts requests, tracks the open shift and turns each request into a job
// holding every byte it must produce.
// ----------------------------------------------------------------------------
module jsce_front import jsce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsce_in_if.sink    i_cmd,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic                  r_open,  n_open;
    logic [COUNT_BITS-1:0] r_bits,  n_bits;
    logic [BIR_W-1:0]      r_bir,   n_bir;
    logic [1:0]            r_kind,  n_kind;
    logic                  r_read,  n_read;
    logic                  r_tms,   n_tms;

    logic                  accept;
    t_job                  job;
    logic [RES_CNT_W-1:0]  k;
    logic [1:0]            kind;
    logic                  hdr;
    logic [LEN_W-1:0]      hdr_len;
    logic [31:0]           whole;
    logic [COUNT_BITS-1:0] bits_m8;
    logic [3:0]            nb;
    logic                  lastbit;

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_push      = accept && (job.count != '0);
    assign o_job       = job;

    always_comb begin
        n_open  = r_open;
        n_bits  = r_bits;
        n_bir   = r_bir;
        n_kind  = r_kind;
        n_read  = r_read;
        n_tms   = r_tms;
        job     = '0;
        k       = '0;
        kind    = r_kind;
        hdr     = 1'b0;
        hdr_len = '0;
        bits_m8 = r_bits - COUNT_BITS'(8);
        whole   = 32'(r_bits >> 3) - ((r_bits[2:0] == 3'd0) ? 32'd1 : 32'd0) - 32'd1;
        nb      = 4'd1;
        lastbit = 1'b0;

        if (i_cmd.mode == MODE_BEGIN) begin
            n_open = 1'b0;
            if (i_cmd.bit_count != '0) begin
                n_open = 1'b1;
                n_bits = i_cmd.bit_count;
                n_bir  = '0;
                n_kind = RUN_BLOCK;
                n_read = i_cmd.read_en;
                n_tms  = i_cmd.end_tms;
            end
            if (r_open || (i_cmd.bit_count == '0)) begin
                job.count = RES_CNT_W'(1);
                job.err   = 1'b1;
            end
        end else if (!r_open) begin
            job.count = RES_CNT_W'(1);
            job.err   = 1'b1;
        end else begin
            // start of a run: pick block, byte run or the final byte
            if (r_bir == '0) begin
                if (32'(r_bits) > 32'(BLOCK_BITS)) begin
                    kind    = RUN_BLOCK;
                    hdr     = 1'b1;
                    hdr_len = LEN_W'(BLOCK_BYTES - 1);
                end else if (r_bits > COUNT_BITS'(8)) begin
                    kind    = RUN_BYTES;
                    hdr     = 1'b1;
                    hdr_len = whole[LEN_W-1:0];
                end else begin
                    kind    = RUN_FINAL;
                end
            end
            n_kind = kind;

            if (hdr) begin
                job.bytes[k] = r_read ? OP_BYTES_RD : OP_BYTES_WR;
                k            = k + RES_CNT_W'(1);
                job.bytes[k] = hdr_len[7:0] & BYTE_MASK;
                k            = k + RES_CNT_W'(1);
                job.bytes[k] = hdr_len[15:8] & BYTE_MASK;
                k            = k + RES_CNT_W'(1);
            end

            case (kind)
                RUN_BLOCK: begin
                    job.bytes[k] = i_cmd.data_byte;
                    k            = k + RES_CNT_W'(1);
                    n_bits       = bits_m8;
                    if (32'(r_bir) >= 32'(BLOCK_BYTES - 1)) begin
                        job.bytes[k] = CMD_FLUSH;
                        k            = k + RES_CNT_W'(1);
                        n_bir        = '0;
                    end else begin
                        n_bir = r_bir + BIR_W'(1);
                    end
                end
                RUN_BYTES: begin
                    job.bytes[k] = i_cmd.data_byte;
                    k            = k + RES_CNT_W'(1);
                    n_bits       = bits_m8;
                    if (bits_m8 <= COUNT_BITS'(8)) begin
                        n_bir = '0;
                    end else begin
                        n_bir = r_bir + BIR_W'(1);
                    end
                end
                default: begin
                    if (r_bits == '0) begin
                        nb = 4'd1;
                    end else if (r_bits > COUNT_BITS'(8)) begin
                        nb = 4'd8;
                    end else begin
                        nb = r_bits[3:0];
                    end
                    if (nb >= 4'd2) begin
                        job.bytes[k] = r_read ? OP_BITS_RD : OP_BITS_WR;
                        k            = k + RES_CNT_W'(1);
                        job.bytes[k] = {4'd0, nb - 4'd2} & NB_MASK;
                        k            = k + RES_CNT_W'(1);
                        job.bytes[k] = i_cmd.data_byte;
                        k            = k + RES_CNT_W'(1);
                    end
                    lastbit      = i_cmd.data_byte[3'(nb - 4'd1)];
                    job.bytes[k] = r_read ? OP_TMS_RD : OP_TMS_WR;
                    k            = k + RES_CNT_W'(1);
                    job.bytes[k] = 8'd0;
                    k            = k + RES_CNT_W'(1);
                    job.bytes[k] = (lastbit ? LASTBIT_FLG : 8'd0) | {7'd0, r_tms};
                    k            = k + RES_CNT_W'(1);
                    if (r_read) begin
                        job.bytes[k] = CMD_FLUSH;
                        k            = k + RES_CNT_W'(1);
                    end
                    n_open = 1'b0;
                    n_bits = '0;
                    n_bir  = '0;
                    n_kind = RUN_BLOCK;
                end
            endcase
            job.count = k;
            job.err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_bits <= '0;
            r_bir  <= '0;
            r_kind <= RUN_BLOCK;
            r_read <= 1'b0;
            r_tms  <= 1'b0;
        end else if (accept) begin
            r_open <= n_open;
            r_bits <= n_bits;
            r_bir  <= n_bir;
            r_kind <= n_kind;
            r_read <= n_read;
            r_tms  <= n_tms;
        end
    end

endmodule

FILE: design/jsce_queue.sv
// ----------------------------------------------------------------------------
// jsce_queue
// Small job FIFO decoupling request intake from byte sequencing.
// ----------------------------------------------------------------------------
module jsce_queue import jsce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = i_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

FILE: design/jsce_back.sv
// ----------------------------------------------------------------------------
// jsce_back
// Walks the head job one byte per cycle, while the output is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module jsce_back import jsce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    jsce_out_if.source o_res
);

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_err;
    logic                 r_last;
    logic [RES_CNT_W-1:0] r_idx;

    logic                 load;
    logic                 is_last;

    assign load    = (!r_valid || o_res.ready) && !i_empty;
    assign is_last = (r_idx == i_head.count - RES_CNT_W'(1));
    assign o_pop   = load && is_last;

    assign o_res.valid    = r_valid;
    assign o_res.cmd_byte = r_byte;
    assign o_res.error    = r_err;
    assign o_res.last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + RES_CNT_W'(1);
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_err  <= i_head.err;
            r_last <= is_last;
        end
    end

endmodule
